@@ hw/rtl/x86abe_pkg.sv @@
// Shared types, opcodes and helper functions for the 16-bit ALU and branch execute unit.
`timescale 1ns / 1ps
package x86abe_pkg;

    // Register file geometry.
    localparam int REG_COUNT = 8;
    localparam int REG_AW    = $clog2(REG_COUNT);
    localparam int WORD_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int FLAG_W    = 6;
    localparam int LEN_W     = 3;
    localparam int DISP_W    = 8;
    localparam int OP_W      = 4;
    localparam int RSEL_W    = 4;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_MOV     = 4'd0;
    localparam logic [OP_W-1:0] OP_ADD     = 4'd1;
    localparam logic [OP_W-1:0] OP_SUB     = 4'd2;
    localparam logic [OP_W-1:0] OP_CMP     = 4'd3;
    localparam logic [OP_W-1:0] OP_JNE     = 4'd4;
    localparam logic [OP_W-1:0] OP_JE      = 4'd5;
    localparam logic [OP_W-1:0] OP_JP      = 4'd6;
    localparam logic [OP_W-1:0] OP_JB      = 4'd7;
    localparam logic [OP_W-1:0] OP_LOOP_NZ = 4'd8;

    // Flag bit positions.
    localparam int FLAG_CF = 0;
    localparam int FLAG_PF = 1;
    localparam int FLAG_AF = 2;
    localparam int FLAG_ZF = 3;
    localparam int FLAG_SF = 4;
    localparam int FLAG_OF = 5;

    // Word index of CX in the register file.
    localparam logic [REG_AW-1:0] REG_CX = 3'd1;

    // One decoded instruction as it travels down the pipeline.
    typedef struct packed {
        logic [OP_W-1:0]   req_type;
        logic [RSEL_W-1:0] dest_reg;
        logic              src_is_reg;
        logic [RSEL_W-1:0] src_reg;
        logic [WORD_W-1:0] immediate;
        logic [DISP_W-1:0] jump_disp;
        logic [LEN_W-1:0]  instr_length;
    } item_t;

    // Outcome of one executed instruction.
    typedef struct packed {
        logic              wr_en;
        logic [WORD_W-1:0] wr_word;
        logic [WORD_W-1:0] dest_value;
        logic [WORD_W-1:0] next_ip;
        logic [FLAG_W-1:0] flags;
        logic              taken;
    } exec_t;

    // Word register that holds a register selector (byte selectors map onto AX..BX).
    function automatic logic [REG_AW-1:0] word_index(input logic [RSEL_W-1:0] sel);
        logic [REG_AW-1:0] idx;
        if (sel[3])
        begin
            idx = sel[2:0];
        end
        else
        begin
            idx = {1'b0, sel[1:0]};
        end
        return idx;
    endfunction

    // Word register touched on the destination side; LOOPNZ always works on CX.
    function automatic logic [REG_AW-1:0] dest_index(input logic [OP_W-1:0] op,
                                                     input logic [RSEL_W-1:0] sel);
        logic [REG_AW-1:0] idx;
        if (op == OP_LOOP_NZ)
        begin
            idx = REG_CX;
        end
        else
        begin
            idx = word_index(sel);
        end
        return idx;
    endfunction

endpackage

@@ hw/rtl/x86_16bit_alu_branch_exec.sv @@
// Top level of the 16-bit ALU and branch execute unit with its register file memories.
//
//  Channel  Direction  Payload                                            Handshake
//  in       into unit  req_type dest_reg src_is_reg src_reg immediate     in_valid / in_stall
//                      jump_disp instr_length
//  out      from unit  dest_value next_ip flag_bits branch_taken          out_valid / out_stall
//
// One instruction per cycle sustained while out_stall is low. An instruction is accepted in
// the cycle its register file reads are issued, executes in the next cycle from the registered
// RAM data, and writes back and loads the output register at the end of the cycle in which
// the execute stage advances.
// A write landing in the same edge as the next read is forwarded from a bypass register.
// Reset clears IP, flags and per-entry valid bits, so every register reads as zero at once.
// A stalled output holds the execute stage, which in turn raises in_stall.
`timescale 1ns / 1ps
module x86_16bit_alu_branch_exec (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  req_type,
    input  logic [3:0]  dest_reg,
    input  logic        src_is_reg,
    input  logic [3:0]  src_reg,
    input  logic [15:0] immediate,
    input  logic signed [7:0] jump_disp,
    input  logic [2:0]  instr_length,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] dest_value,
    output logic [15:0] next_ip,
    output logic [5:0]  flag_bits,
    output logic        branch_taken
);

    logic                              in_acc;
    logic                              s1_advance;
    logic                              s1_valid_reg;
    logic                              s1_valid_next;
    x86abe_pkg::item_t                 s1_item_reg;
    logic [x86abe_pkg::REG_AW-1:0]     s1_a_addr_reg;
    logic [x86abe_pkg::REG_AW-1:0]     s1_b_addr_reg;
    logic                              fwd_valid_reg;
    logic                              fwd_valid_next;
    logic [x86abe_pkg::REG_AW-1:0]     fwd_addr_reg;
    logic [x86abe_pkg::WORD_W-1:0]     fwd_data_reg;
    logic [x86abe_pkg::REG_COUNT-1:0]  rf_valid_reg;
    logic [x86abe_pkg::REG_COUNT-1:0]  rf_valid_next;
    logic [x86abe_pkg::WORD_W-1:0]     ip_reg;
    logic [x86abe_pkg::WORD_W-1:0]     ip_next;
    logic [x86abe_pkg::FLAG_W-1:0]     flags_reg;
    logic [x86abe_pkg::FLAG_W-1:0]     flags_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [x86abe_pkg::WORD_W-1:0]     dest_value_reg;
    logic [x86abe_pkg::WORD_W-1:0]     next_ip_reg;
    logic [x86abe_pkg::FLAG_W-1:0]     flag_bits_reg;
    logic                              branch_taken_reg;
    x86abe_pkg::item_t                 in_item;
    logic [x86abe_pkg::REG_AW-1:0]     rd_a_addr;
    logic [x86abe_pkg::REG_AW-1:0]     rd_b_addr;
    logic [x86abe_pkg::WORD_W-1:0]     ram_a_q;
    logic [x86abe_pkg::WORD_W-1:0]     ram_b_q;
    logic [x86abe_pkg::WORD_W-1:0]     a_word;
    logic [x86abe_pkg::WORD_W-1:0]     b_word;
    logic                              ram_wr_en;
    x86abe_pkg::exec_t                 exec_res;

    // Handshake control.
    assign s1_advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_acc     = in_valid && !in_stall;
    assign ram_wr_en  = s1_advance && exec_res.wr_en;

    // Pack the input transaction.
    always_comb
    begin
        in_item.req_type     = req_type;
        in_item.dest_reg     = dest_reg;
        in_item.src_is_reg   = src_is_reg;
        in_item.src_reg      = src_reg;
        in_item.immediate    = immediate;
        in_item.jump_disp    = jump_disp;
        in_item.instr_length = instr_length;
        rd_a_addr            = x86abe_pkg::dest_index(req_type, dest_reg);
        rd_b_addr            = x86abe_pkg::word_index(src_reg);
    end

    // Two copies of the register file give two read ports; both take every write.
    x86abe_ram #(
        .WIDTH (x86abe_pkg::WORD_W),
        .DEPTH (x86abe_pkg::REG_COUNT)
    ) u_ram_a (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (s1_a_addr_reg),
        .wr_data (exec_res.wr_word),
        .rd_en   (in_acc),
        .rd_addr (rd_a_addr),
        .rd_data (ram_a_q)
    );

    x86abe_ram #(
        .WIDTH (x86abe_pkg::WORD_W),
        .DEPTH (x86abe_pkg::REG_COUNT)
    ) u_ram_b (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (s1_a_addr_reg),
        .wr_data (exec_res.wr_word),
        .rd_en   (in_acc),
        .rd_addr (rd_b_addr),
        .rd_data (ram_b_q)
    );

    // Operand words: bypass the write of the accept edge, unwritten entries read as zero.
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_a_addr_reg))
        begin
            a_word = fwd_data_reg;
        end
        else if (rf_valid_reg[s1_a_addr_reg])
        begin
            a_word = ram_a_q;
        end
        else
        begin
            a_word = '0;
        end

        if (fwd_valid_reg && (fwd_addr_reg == s1_b_addr_reg))
        begin
            b_word = fwd_data_reg;
        end
        else if (rf_valid_reg[s1_b_addr_reg])
        begin
            b_word = ram_b_q;
        end
        else
        begin
            b_word = '0;
        end
    end

    x86abe_exec u_exec (
        .item   (s1_item_reg),
        .a_word (a_word),
        .b_word (b_word),
        .ip     (ip_reg),
        .flags  (flags_reg),
        .res    (exec_res)
    );

    // Next-state logic for control registers.
    always_comb
    begin
        s1_valid_next  = in_acc ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_reg);
        fwd_valid_next = in_acc ? ram_wr_en : fwd_valid_reg;
        rf_valid_next  = rf_valid_reg;
        if (ram_wr_en)
        begin
            rf_valid_next[s1_a_addr_reg] = 1'b1;
        end
        ip_next        = s1_advance ? exec_res.next_ip : ip_reg;
        flags_next     = s1_advance ? exec_res.flags : flags_reg;
        if (s1_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_stall)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            rf_valid_reg  <= '0;
            ip_reg        <= '0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            fwd_valid_reg <= fwd_valid_next;
            rf_valid_reg  <= rf_valid_next;
            ip_reg        <= ip_next;
            flags_reg     <= flags_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers of the execute stage and the bypass.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_item_reg   <= in_item;
            s1_a_addr_reg <= rd_a_addr;
            s1_b_addr_reg <= rd_b_addr;
            fwd_addr_reg  <= s1_a_addr_reg;
            fwd_data_reg  <= exec_res.wr_word;
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            dest_value_reg   <= exec_res.dest_value;
            next_ip_reg      <= exec_res.next_ip;
            flag_bits_reg    <= exec_res.flags;
            branch_taken_reg <= exec_res.taken;
        end
    end

    assign out_valid    = out_valid_reg;
    assign dest_value   = dest_value_reg;
    assign next_ip      = next_ip_reg;
    assign flag_bits    = flag_bits_reg;
    assign branch_taken = branch_taken_reg;

    // Every instruction leaving the execute stage produces an output transaction.
    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> out_valid_reg)
        else $error("execute stage advanced without loading the output register");

    // IP only moves when an instruction retires.
    a_ip_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_advance |=> $stable(ip_reg))
        else $error("IP changed without a retiring instruction");

    // Flags only move when an instruction retires.
    a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_advance |=> $stable(flags_reg))
        else $error("flags changed without a retiring instruction");

    // The register file is only written by a retiring instruction in the execute stage.
    a_write_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (s1_valid_reg && !(out_valid_reg && out_stall)))
        else $error("register file written outside a retiring instruction");

    // A held output register keeps the execute stage from retiring.
    a_stall_blocks_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(flags_reg) && $stable(ip_reg))
        else $error("execute stage retired while the output was stalled");

endmodule

@@ hw/rtl/x86abe_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read port.
`timescale 1ns / 1ps
module x86abe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; a same-cycle write is not visible until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/x86abe_exec.sv @@
// Execute logic: operand selection, add and subtract with flags, branch and IP update.
`timescale 1ns / 1ps
module x86abe_exec (
    input  x86abe_pkg::item_t                 item,
    input  logic [x86abe_pkg::WORD_W-1:0]     a_word,
    input  logic [x86abe_pkg::WORD_W-1:0]     b_word,
    input  logic [x86abe_pkg::WORD_W-1:0]     ip,
    input  logic [x86abe_pkg::FLAG_W-1:0]     flags,
    output x86abe_pkg::exec_t                 res
);

    logic                          wide;
    logic [x86abe_pkg::WORD_W-1:0] a_op;
    logic [x86abe_pkg::BYTE_W-1:0] src_byte;
    logic [x86abe_pkg::WORD_W-1:0] src_raw;
    logic [x86abe_pkg::WORD_W-1:0] src_op;
    logic [x86abe_pkg::WORD_W:0]   sum_full;
    logic [x86abe_pkg::WORD_W:0]   dif_full;
    logic [4:0]                    nib_sum;
    logic                          is_add;
    logic [x86abe_pkg::WORD_W-1:0] res_raw;
    logic [x86abe_pkg::WORD_W-1:0] res_m;
    logic                          a_sign;
    logic                          s_sign;
    logic                          r_sign;
    logic                          cf;
    logic                          af;
    logic                          of;
    logic [x86abe_pkg::FLAG_W-1:0] new_flags;
    logic [x86abe_pkg::WORD_W-1:0] mov_word;
    logic [x86abe_pkg::WORD_W-1:0] alu_word;
    logic [x86abe_pkg::WORD_W-1:0] ip_len;
    logic [x86abe_pkg::WORD_W-1:0] ip_branch;
    logic [x86abe_pkg::WORD_W-1:0] cx_dec;
    logic                          cond;

    // Merge an operation result into the full word register.
    function automatic logic [x86abe_pkg::WORD_W-1:0] merge_word(
        input logic                          is_wide,
        input logic                          high_byte,
        input logic [x86abe_pkg::WORD_W-1:0] old_word,
        input logic [x86abe_pkg::WORD_W-1:0] value
    );
        logic [x86abe_pkg::WORD_W-1:0] w;
        if (is_wide)
        begin
            w = value;
        end
        else if (high_byte)
        begin
            w = {value[7:0], old_word[7:0]};
        end
        else
        begin
            w = {old_word[15:8], value[7:0]};
        end
        return w;
    endfunction

    // Operand selection at the operation width.
    always_comb
    begin
        wide = item.dest_reg[3];
        if (wide)
        begin
            a_op = a_word;
        end
        else if (item.dest_reg[2])
        begin
            a_op = {8'h00, a_word[15:8]};
        end
        else
        begin
            a_op = {8'h00, a_word[7:0]};
        end

        src_byte = item.src_reg[2] ? b_word[15:8] : b_word[7:0];
        if (!item.src_is_reg)
        begin
            src_raw = item.immediate;
        end
        else if (item.src_reg[3])
        begin
            src_raw = b_word;
        end
        else
        begin
            src_raw = {{8{src_byte[7]}}, src_byte};
        end
        src_op = wide ? src_raw : {8'h00, src_raw[7:0]};
    end

    // Adder, subtractor and flag generation.
    always_comb
    begin
        is_add   = (item.req_type == x86abe_pkg::OP_ADD);
        sum_full = {1'b0, a_op} + {1'b0, src_op};
        dif_full = {1'b0, a_op} - {1'b0, src_op};
        nib_sum  = {1'b0, a_op[3:0]} + {1'b0, src_op[3:0]};
        res_raw  = is_add ? sum_full[15:0] : dif_full[15:0];
        res_m    = wide ? res_raw : {8'h00, res_raw[7:0]};

        a_sign = wide ? a_op[15] : a_op[7];
        s_sign = wide ? src_op[15] : src_op[7];
        r_sign = wide ? res_m[15] : res_m[7];

        if (is_add)
        begin
            cf = wide ? sum_full[16] : sum_full[8];
            af = nib_sum[4];
            of = (a_sign == s_sign) && (a_sign != r_sign);
        end
        else
        begin
            cf = dif_full[16];
            af = (a_op[3:0] < src_op[3:0]);
            of = (a_sign != s_sign) && (a_sign != r_sign);
        end

        new_flags = '0;
        new_flags[x86abe_pkg::FLAG_CF] = cf;
        new_flags[x86abe_pkg::FLAG_PF] = ~^res_m[7:0];
        new_flags[x86abe_pkg::FLAG_AF] = af;
        new_flags[x86abe_pkg::FLAG_ZF] = (res_m == '0);
        new_flags[x86abe_pkg::FLAG_SF] = r_sign;
        new_flags[x86abe_pkg::FLAG_OF] = of;
    end

    // Instruction pointer and loop counter arithmetic.
    always_comb
    begin
        ip_len    = ip + {13'd0, item.instr_length};
        ip_branch = ip_len + {{8{item.jump_disp[7]}}, item.jump_disp};
        cx_dec    = a_word - 16'd1;
        mov_word  = merge_word(wide, item.dest_reg[2], a_word, src_op);
        alu_word  = merge_word(wide, item.dest_reg[2], a_word, res_m);
    end

    // Per-operation outcome.
    always_comb
    begin
        res.wr_en      = 1'b0;
        res.wr_word    = alu_word;
        res.dest_value = '0;
        res.flags      = flags;
        cond           = 1'b0;
        case (item.req_type)
            x86abe_pkg::OP_MOV:
            begin
                res.wr_en      = 1'b1;
                res.wr_word    = mov_word;
                res.dest_value = mov_word;
            end
            x86abe_pkg::OP_ADD, x86abe_pkg::OP_SUB:
            begin
                res.wr_en      = 1'b1;
                res.wr_word    = alu_word;
                res.dest_value = alu_word;
                res.flags      = new_flags;
            end
            x86abe_pkg::OP_CMP:
            begin
                res.dest_value = a_word;
                res.flags      = new_flags;
            end
            x86abe_pkg::OP_JNE:
            begin
                cond = !flags[x86abe_pkg::FLAG_ZF];
            end
            x86abe_pkg::OP_JE:
            begin
                cond = flags[x86abe_pkg::FLAG_ZF];
            end
            x86abe_pkg::OP_JP:
            begin
                cond = flags[x86abe_pkg::FLAG_PF];
            end
            x86abe_pkg::OP_JB:
            begin
                cond = flags[x86abe_pkg::FLAG_CF];
            end
            x86abe_pkg::OP_LOOP_NZ:
            begin
                res.wr_en      = 1'b1;
                res.wr_word    = cx_dec;
                res.dest_value = cx_dec;
                cond           = (cx_dec != '0) && !flags[x86abe_pkg::FLAG_ZF];
            end
            default:
            begin
                cond = 1'b0;
            end
        endcase
        res.taken   = cond;
        res.next_ip = cond ? ip_branch : ip_len;
    end

endmodule

@@ sim/x86_16bit_alu_branch_exec_tb.sv @@
// Self-checking testbench for the 16-bit ALU and branch execute unit.
`timescale 1ns / 1ps
module x86_16bit_alu_branch_exec_tb;

    localparam int INSTR_TARGET = 1550;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 10;

    // Register selectors in 8086 encoding order.
    typedef enum logic [3:0] {
        SEL_AL, SEL_CL, SEL_DL, SEL_BL, SEL_AH, SEL_CH, SEL_DH, SEL_BH,
        SEL_AX, SEL_CX, SEL_DX, SEL_BX, SEL_SP, SEL_BP, SEL_SI, SEL_DI
    } reg_sel_t;

    // Stall behaviors of the result receiver.
    typedef enum logic [1:0] {
        STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC
    } stall_mode_t;

    // Architectural outcome of one retired instruction.
    typedef struct packed {
        logic [15:0] dest_value;
        logic [15:0] next_ip;
        logic [5:0]  flags;
        logic        taken;
    } retire_t;

    // Architectural state of the unit and the outcomes still to come out of it.
    class arch_state_model;
        logic [15:0] gpr [8];
        logic [15:0] ip;
        logic [5:0]  flags;
        retire_t     expected_q [$];
        int          errors;

        function new();
            foreach (gpr[i])
            begin
                gpr[i] = '0;
            end
            ip = '0;
            flags = '0;
            errors = 0;
        endfunction

        function logic [15:0] read_sel(input logic [3:0] sel);
            if (sel[3])
            begin
                return gpr[sel[2:0]];
            end
            if (sel[2])
            begin
                return {8'h00, gpr[{1'b0, sel[1:0]}][15:8]};
            end
            return {8'h00, gpr[{1'b0, sel[1:0]}][7:0]};
        endfunction

        function void write_sel(input logic [3:0] sel, input logic [15:0] v);
            if (sel[3])
            begin
                gpr[sel[2:0]] = v;
            end
            else if (sel[2])
            begin
                gpr[{1'b0, sel[1:0]}][15:8] = v[7:0];
            end
            else
            begin
                gpr[{1'b0, sel[1:0]}][7:0] = v[7:0];
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Executes one accepted instruction and queues its outcome.
        function void retire(input x86abe_pkg::item_t it);
            retire_t     r;
            logic        wide, cf, af, of, cond;
            logic [15:0] mask, msb, src, a, res, disp16;
            logic [16:0] full;
            logic [4:0]  nib;
            logic [5:0]  f;
            r = '0;
            wide = it.dest_reg[3];
            mask = wide ? 16'hffff : 16'h00ff;
            msb = wide ? 16'h8000 : 16'h0080;
            disp16 = {{8{it.jump_disp[7]}}, it.jump_disp};
            ip = ip + 16'(it.instr_length);

            // Byte source registers are sign-extended before being cut to width.
            if (it.src_is_reg)
            begin
                src = read_sel(it.src_reg);
                if (!it.src_reg[3] && src[7])
                begin
                    src[15:8] = 8'hff;
                end
            end
            else
            begin
                src = it.immediate;
            end
            src = src & mask;

            if (it.req_type <= x86abe_pkg::OP_CMP)
            begin
                a = read_sel(it.dest_reg) & mask;
                if (it.req_type == x86abe_pkg::OP_MOV)
                begin
                    write_sel(it.dest_reg, src);
                end
                else
                begin
                    if (it.req_type == x86abe_pkg::OP_ADD)
                    begin
                        full = {1'b0, a} + {1'b0, src};
                        res = full[15:0] & mask;
                        cf = wide ? full[16] : full[8];
                        nib = a[3:0] + src[3:0];
                        af = nib[4];
                        of = |(~(a ^ src) & (a ^ res) & msb);
                    end
                    else
                    begin
                        res = (a - src) & mask;
                        cf = a < src;
                        af = a[3:0] < src[3:0];
                        of = |((a ^ src) & (a ^ res) & msb);
                    end
                    f = '0;
                    f[x86abe_pkg::FLAG_CF] = cf;
                    f[x86abe_pkg::FLAG_PF] = ~^res[7:0];
                    f[x86abe_pkg::FLAG_AF] = af;
                    f[x86abe_pkg::FLAG_ZF] = (res == 16'h0000);
                    f[x86abe_pkg::FLAG_SF] = |(res & msb);
                    f[x86abe_pkg::FLAG_OF] = of;
                    flags = f;
                    if (it.req_type != x86abe_pkg::OP_CMP)
                    begin
                        write_sel(it.dest_reg, res);
                    end
                end
                r.dest_value = gpr[wide ? it.dest_reg[2:0] : {1'b0, it.dest_reg[1:0]}];
            end
            else if (it.req_type <= x86abe_pkg::OP_JB)
            begin
                case (it.req_type)
                    x86abe_pkg::OP_JNE: cond = !flags[x86abe_pkg::FLAG_ZF];
                    x86abe_pkg::OP_JE:  cond = flags[x86abe_pkg::FLAG_ZF];
                    x86abe_pkg::OP_JP:  cond = flags[x86abe_pkg::FLAG_PF];
                    default:            cond = flags[x86abe_pkg::FLAG_CF];
                endcase
                if (cond)
                begin
                    ip = ip + disp16;
                    r.taken = 1'b1;
                end
            end
            else if (it.req_type == x86abe_pkg::OP_LOOP_NZ)
            begin
                // CX counts down without touching the flags.
                gpr[x86abe_pkg::REG_CX] = gpr[x86abe_pkg::REG_CX] - 16'd1;
                if (gpr[x86abe_pkg::REG_CX] != 16'h0000 && !flags[x86abe_pkg::FLAG_ZF])
                begin
                    ip = ip + disp16;
                    r.taken = 1'b1;
                end
                r.dest_value = gpr[x86abe_pkg::REG_CX];
            end

            r.next_ip = ip;
            r.flags = flags;
            expected_q.push_back(r);
        endfunction

        // Compares one result transaction with the oldest queued outcome.
        function void check_result(input retire_t got);
            retire_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result transaction: expected none, actual %h %h %b %b",
                         $time, got.dest_value, got.next_ip, got.flags, got.taken);
                return;
            end
            want = expected_q.pop_front();
            if (got !== want)
            begin
                errors++;
                if (got.dest_value !== want.dest_value)
                begin
                    $display("%0t: dest_value expected %h actual %h",
                             $time, want.dest_value, got.dest_value);
                end
                if (got.next_ip !== want.next_ip)
                begin
                    $display("%0t: next_ip expected %h actual %h",
                             $time, want.next_ip, got.next_ip);
                end
                if (got.flags !== want.flags)
                begin
                    $display("%0t: flag_bits expected %b actual %b",
                             $time, want.flags, got.flags);
                end
                if (got.taken !== want.taken)
                begin
                    $display("%0t: branch_taken expected %b actual %b",
                             $time, want.taken, got.taken);
                end
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [3:0]        req_type = '0;
    logic [3:0]        dest_reg = '0;
    logic              src_is_reg = 1'b0;
    logic [3:0]        src_reg = '0;
    logic [15:0]       immediate = '0;
    logic signed [7:0] jump_disp = '0;
    logic [2:0]        instr_length = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [15:0]       dest_value;
    logic [15:0]       next_ip;
    logic [5:0]        flag_bits;
    logic              branch_taken;

    arch_state_model cpu = new();
    int          cycle_count = 0;
    int          instr_count = 0;
    int          burst_left = 1;
    int          stall_window = 0;
    stall_mode_t stall_mode = STALL_NONE;

    x86_16bit_alu_branch_exec dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .dest_reg     (dest_reg),
        .src_is_reg   (src_is_reg),
        .src_reg      (src_reg),
        .immediate    (immediate),
        .jump_disp    (jump_disp),
        .instr_length (instr_length),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .dest_value   (dest_value),
        .next_ip      (next_ip),
        .flag_bits    (flag_bits),
        .branch_taken (branch_taken)
    );

    // Free-running clock.
    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Receiver stall behavior changes over windows of random length.
    always @(negedge clk)
    begin
        if (stall_window == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_window = $urandom_range(40, 300);
        end
        stall_window--;
        case (stall_mode)
            STALL_NONE:  out_stall = 1'b0;
            STALL_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall = ($urandom_range(0, 9) < 7);
            default:     out_stall = ((cycle_count % 5) < 2);
        endcase
    end

    // Result transactions are checked as they are accepted.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            cpu.check_result({dest_value, next_ip, flag_bits, branch_taken});
        end
    end

    function automatic x86abe_pkg::item_t make_instr(input logic [3:0] op,
                                                     input logic [3:0] dsel,
                                                     input logic isreg, input logic [3:0] ssel,
                                                     input logic [15:0] imm,
                                                     input logic [7:0] disp,
                                                     input logic [2:0] len);
        x86abe_pkg::item_t it;
        it.req_type = op;
        it.dest_reg = dsel;
        it.src_is_reg = isreg;
        it.src_reg = ssel;
        it.immediate = imm;
        it.jump_disp = disp;
        it.instr_length = len;
        return it;
    endfunction

    // Immediates lean toward the values at the edges of byte and word arithmetic.
    function automatic logic [15:0] rand_imm();
        case ($urandom_range(0, 21))
            0:       return 16'h0000;
            1:       return 16'h0001;
            2:       return 16'h000f;
            3:       return 16'h0010;
            4:       return 16'h007f;
            5:       return 16'h0080;
            6:       return 16'h00ff;
            7:       return 16'h0100;
            8:       return 16'h7fff;
            9:       return 16'h8000;
            10:      return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic x86abe_pkg::item_t rand_alu(input logic [3:0] op);
        return make_instr(op, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                          4'($urandom_range(0, 15)), rand_imm(), 8'($urandom),
                          3'($urandom_range(0, 7)));
    endfunction

    // Drives one instruction, waits for its acceptance, and at the end of a burst may idle before the next.
    task automatic send_instr(input x86abe_pkg::item_t it);
        int gap;
        @(negedge clk);
        in_valid = 1'b1;
        req_type = it.req_type;
        dest_reg = it.dest_reg;
        src_is_reg = it.src_is_reg;
        src_reg = it.src_reg;
        immediate = it.immediate;
        jump_disp = it.jump_disp;
        instr_length = it.instr_length;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        cpu.retire(it);
        instr_count++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    // Counted loop: load CX, then an ALU body closed by LOOPNZ back-edges.
    task automatic run_loop_sequence();
        int trips;
        trips = $urandom_range(1, 8);
        send_instr(make_instr(x86abe_pkg::OP_MOV, SEL_CX, 1'b0, 4'($urandom_range(0, 15)),
                              16'($urandom_range(0, 6)), 8'($urandom),
                              3'($urandom_range(0, 7))));
        repeat (trips)
        begin
            send_instr(rand_alu(4'($urandom_range(x86abe_pkg::OP_ADD, x86abe_pkg::OP_CMP))));
            send_instr(make_instr(x86abe_pkg::OP_LOOP_NZ, 4'($urandom_range(0, 15)),
                                  1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                                  16'($urandom), 8'($urandom_range(128, 255)),
                                  3'($urandom_range(0, 7))));
        end
    endtask

    // Flag-setting operation followed by a conditional jump that tests it.
    task automatic run_compare_branch();
        send_instr(rand_alu(4'($urandom_range(x86abe_pkg::OP_ADD, x86abe_pkg::OP_CMP))));
        send_instr(rand_alu(4'($urandom_range(x86abe_pkg::OP_JNE, x86abe_pkg::OP_JB))));
    endtask

    // Timeout watchdog.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("x86_16bit_alu_branch_exec_tb NOT OK");
        $finish;
    end

    // Stimulus and end of run.
    initial
    begin
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes of widths, every operation and flag, sign extension, wrap.
        send_instr(make_instr(x86abe_pkg::OP_MOV, SEL_AX,
                              1'b0, SEL_AL, 16'hffff, 8'h00, 3'd3));
        send_instr(make_instr(x86abe_pkg::OP_MOV, SEL_AH,
                              1'b0, SEL_AL, 16'h1280, 8'h00, 3'd2));
        send_instr(make_instr(x86abe_pkg::OP_ADD, SEL_AL,
                              1'b0, SEL_AL, 16'h0001, 8'h00, 3'd2));
        send_instr(make_instr(x86abe_pkg::OP_JE, SEL_AL,
                              1'b0, SEL_AL, 16'h0000, 8'h7f, 3'd2));
        send_instr(make_instr(x86abe_pkg::OP_JNE, SEL_AL,
                              1'b0, SEL_AL, 16'h0000, 8'h80, 3'd2));
        send_instr(make_instr(x86abe_pkg::OP_JB, SEL_DI,
                              1'b1, SEL_DI, 16'hffff, 8'h80, 3'd7));
        send_instr(make_instr(x86abe_pkg::OP_JP, SEL_AL,
                              1'b0, SEL_AL, 16'h0000, 8'h10, 3'd2));
        send_instr(make_instr(x86abe_pkg::OP_MOV, SEL_BX,
                              1'b0, SEL_AL, 16'h7fff, 8'h00, 3'd0));
        send_instr(make_instr(x86abe_pkg::OP_ADD, SEL_BX,
                              1'b0, SEL_AL, 16'h0001, 8'h00, 3'd4));
        send_instr(make_instr(x86abe_pkg::OP_SUB, SEL_DX,
                              1'b0, SEL_AL, 16'h0001, 8'h00, 3'd4));
        send_instr(make_instr(x86abe_pkg::OP_CMP, SEL_AX,
                              1'b1, SEL_BX, 16'h0000, 8'h00, 3'd2));
        send_instr(make_instr(x86abe_pkg::OP_MOV, SEL_SI,
                              1'b1, SEL_AH, 16'h0000, 8'h00, 3'd2));
        send_instr(make_instr(x86abe_pkg::OP_MOV, SEL_CL,
                              1'b1, SEL_SI, 16'h0000, 8'h00, 3'd2));
        send_instr(make_instr(x86abe_pkg::OP_ADD, SEL_DH,
                              1'b1, SEL_BH, 16'h0000, 8'h00, 3'd1));
        send_instr(make_instr(x86abe_pkg::OP_SUB, SEL_SP,
                              1'b1, SEL_SI, 16'h0000, 8'h00, 3'd5));
        send_instr(make_instr(x86abe_pkg::OP_SUB, SEL_BP,
                              1'b0, SEL_AL, 16'h8000, 8'h00, 3'd6));
        send_instr(make_instr(x86abe_pkg::OP_ADD, SEL_CH,
                              1'b0, SEL_AL, 16'h007f, 8'h00, 3'd2));
        send_instr(make_instr(x86abe_pkg::OP_ADD, SEL_CH,
                              1'b0, SEL_AL, 16'h0001, 8'h00, 3'd2));
        send_instr(make_instr(x86abe_pkg::OP_MOV, SEL_CX,
                              1'b0, SEL_AL, 16'h0002, 8'h00, 3'd3));
        send_instr(make_instr(x86abe_pkg::OP_CMP, SEL_DL,
                              1'b0, SEL_AL, 16'h0001, 8'h00, 3'd3));
        send_instr(make_instr(x86abe_pkg::OP_LOOP_NZ, SEL_AL,
                              1'b0, SEL_AL, 16'h0000, 8'hfe, 3'd2));
        send_instr(make_instr(x86abe_pkg::OP_LOOP_NZ, SEL_AL,
                              1'b0, SEL_AL, 16'h0000, 8'hfe, 3'd2));
        send_instr(make_instr(x86abe_pkg::OP_LOOP_NZ, SEL_AL,
                              1'b0, SEL_AL, 16'h0000, 8'h80, 3'd2));
        send_instr(make_instr(4'd15, SEL_DI, 1'b1, SEL_DI, 16'hffff, 8'hff, 3'd7));
        send_instr(make_instr(4'd9, SEL_AL, 1'b0, SEL_AL, 16'h0000, 8'h00, 3'd7));

        // Random: mostly well-formed flag/branch and loop sequences, some loose noise.
        while (instr_count < INSTR_TARGET)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: run_compare_branch();
                4, 5:       run_loop_sequence();
                6:          send_instr(rand_alu(4'($urandom_range(
                                x86abe_pkg::OP_LOOP_NZ + 1, 15))));
                default:    send_instr(rand_alu(4'($urandom_range(
                                x86abe_pkg::OP_MOV, x86abe_pkg::OP_LOOP_NZ))));
            endcase
        end

        @(negedge clk);
        in_valid = 1'b0;
        while (cpu.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (cpu.errors == 0 && cpu.pending() == 0)
        begin
            $display("x86_16bit_alu_branch_exec_tb OK");
        end
        else
        begin
            $display("x86_16bit_alu_branch_exec_tb NOT OK");
        end
        $finish;
    end

endmodule
